### hw/rtl/raia_pkg.sv
// ---------------------------------------------------------------------------
// raia_pkg: shared types and constants of the aggregation ID allocator
// Field widths, request and status codes, table entry layouts, FSM states.
// ---------------------------------------------------------------------------
package raia_pkg;

  localparam int AGG_W  = 6;
  localparam int PORT_W = 7;
  localparam int PIPE_W = 1;
  localparam int TRK_W  = 10;
  localparam int CNT_W  = 16;
  localparam int ST_W   = 3;
  localparam int REQ_W  = 2;

  localparam int DEF_IDS_PER_PIPE = 64;
  localparam int DEF_NUM_TRUNKS   = 1024;
  localparam int DEF_NUM_PORTS    = 128;
  localparam int DEF_PIPE_CNT     = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD,
    REQ_DEL,
    REQ_LOOKUP,
    REQ_LAST
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 3'd0,
    ST_BAD  = 3'd1,
    ST_FULL = 3'd2,
    ST_NOID = 3'd3,
    ST_OVF  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_PRD,
    S_TRD,
    S_WALK,
    S_WEND,
    S_OUT
  } state_e;

  typedef struct packed {
    logic             has_id;
    logic [AGG_W-1:0] id;
    logic [CNT_W-1:0] cnt;
  } trunk_ent_t;

  typedef struct packed {
    logic              has_id;
    logic [AGG_W-1:0]  id;
    logic [CNT_W-1:0]  cnt;
    logic              in_trunk;
    logic [TRK_W-1:0]  trunk;
    logic [PIPE_W-1:0] pipe;
  } port_ent_t;

  typedef struct packed {
    logic             found;
    logic [AGG_W-1:0] id;
  } free_t;

endpackage

### hw/rtl/raia_idfind.sv
// ---------------------------------------------------------------------------
// raia_idfind: lowest free ID search
// Registered per-byte search of the used-map, then a byte-level pick.
// ---------------------------------------------------------------------------
module raia_idfind
  import raia_pkg::*;
#(
  parameter int IDS_PER_PIPE = DEF_IDS_PER_PIPE
) (
  input  logic                    clk_i,
  input  logic [IDS_PER_PIPE-1:0] used_i,
  output free_t                   free_o
);

  localparam int NG = (IDS_PER_PIPE + 7) / 8;

  logic [NG*8-1:0] pad;
  logic [NG-1:0]   grp_any_d, grp_any_q;
  logic [2:0]      grp_low_d [NG];
  logic [2:0]      grp_low_q [NG];

  for (genvar g = 0; g < NG * 8; g++) begin : g_pad
    if (g < IDS_PER_PIPE) begin : g_id
      assign pad[g] = used_i[g];
    end else begin : g_fill
      assign pad[g] = 1'b1;
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_d[g] = ~&pad[g*8 +: 8];
      grp_low_d[g] = '0;
      for (int b = 7; b >= 0; b--) begin
        if (!pad[g*8+b]) grp_low_d[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    grp_low_q <= grp_low_d;
  end

  always_comb begin
    free_o = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        free_o.found = 1'b1;
        free_o.id    = AGG_W'(g * 8 + int'(grp_low_q[g]));
      end
    end
  end

endmodule

### hw/rtl/refcounted_aggregation_id_allocator.sv
// ---------------------------------------------------------------------------
// refcounted_aggregation_id_allocator: per-pipe aggregation ID allocator
// Reference-counted IDs for ports and trunks, held in port and trunk tables.
// ---------------------------------------------------------------------------
// channel  | handshake          | payload
// request  | valid_i / stall_o  | req_type_i port_i pipe_i trunk_valid_i trunk_id_i
// result   | valid_o / stall_i  | status_o agg_id_o trunk_valid_out_o trunk_id_out_o
//          |                    | is_last_member_o map_write_o map_clear_o
//
// Add, delete, lookup: port table read, trunk table read, update, result
// register, in that order. Last-member check: port table read, then a walk
// of the port table through its single read port, then the result register.
// After reset a clearing pass zeroes the port and trunk tables with stall_o high.
// One item at a time; stall_o stays high until its result is taken.
// ---------------------------------------------------------------------------
module refcounted_aggregation_id_allocator
  import raia_pkg::*;
#(
  parameter int IDS_PER_PIPE = DEF_IDS_PER_PIPE,
  parameter int NUM_TRUNKS   = DEF_NUM_TRUNKS,
  parameter int NUM_PORTS    = DEF_NUM_PORTS,
  parameter int PIPE_CNT     = DEF_PIPE_CNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [PORT_W-1:0] port_i,
  input  logic [PIPE_W-1:0] pipe_i,
  input  logic              trunk_valid_i,
  input  logic [TRK_W-1:0]  trunk_id_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [AGG_W-1:0]  agg_id_o,
  output logic              trunk_valid_out_o,
  output logic [TRK_W-1:0]  trunk_id_out_o,
  output logic              is_last_member_o,
  output logic              map_write_o,
  output logic              map_clear_o
);

  localparam int TDEPTH = PIPE_CNT * NUM_TRUNKS;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int PAW    = $clog2(NUM_PORTS);
  localparam int IW     = $clog2(IDS_PER_PIPE);
  localparam int PSW    = (PIPE_CNT > 1) ? $clog2(PIPE_CNT) : 1;
  localparam int CLR_N  = (TDEPTH > NUM_PORTS) ? TDEPTH : NUM_PORTS;
  localparam int CAW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam int WCW    = $clog2(NUM_PORTS);

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [PORT_W-1:0] port_q, port_d;
  logic [PIPE_W-1:0] pipe_q, pipe_d;
  logic              tv_q, tv_d;
  logic [TRK_W-1:0]  tg_q, tg_d;
  logic              rbad_q, rbad_d;
  port_ent_t         pe_q, pe_d;
  logic [TAW-1:0]    taddr_q, taddr_d;
  logic [WCW-1:0]    wcnt_q, wcnt_d;
  logic              wvld_q, wvld_d;
  logic [1:0]        nmatch_q, nmatch_d;
  logic [CAW-1:0]    clr_q, clr_d;

  status_e           st_q, st_d;
  logic [AGG_W-1:0]  id_q, id_d;
  logic              otv_q, otv_d;
  logic [TRK_W-1:0]  otid_q, otid_d;
  logic              last_q, last_d;
  logic              mw_q, mw_d;
  logic              mc_q, mc_d;

  logic [IDS_PER_PIPE-1:0] used_q [PIPE_CNT];
  logic [PSW-1:0]          pidx;

  port_ent_t  pmem [NUM_PORTS];
  trunk_ent_t tmem [TDEPTH];
  port_ent_t  prd_q, pwd;
  trunk_ent_t trd_q, twd;
  logic [PAW-1:0] pra, pwa;
  logic [TAW-1:0] tra, twa;
  logic           pwe, twe;
  logic [TRK_W-1:0] trk_sel;

  free_t fr;

  // update results of the trunk read cycle
  status_e          u_st;
  logic [AGG_W-1:0] u_id;
  logic             u_tv, u_mw, u_mc, u_claim, u_rel;
  logic [TRK_W-1:0] u_tid;
  port_ent_t        u_pe;
  trunk_ent_t       u_te;
  logic             u_pwe, u_twe;
  logic             tg_ok, wmatch;
  logic [1:0]       n_inc;

  assign pidx = PSW'(pipe_q);

  raia_idfind #(
    .IDS_PER_PIPE(IDS_PER_PIPE)
  ) u_idfind (
    .clk_i (clk_i),
    .used_i(used_q[pidx]),
    .free_o(fr)
  );

  always_ff @(posedge clk_i) begin
    if (pwe) pmem[pwa] <= pwd;
    prd_q <= pmem[pra];
  end

  always_ff @(posedge clk_i) begin
    if (twe) tmem[twa] <= twd;
    trd_q <= tmem[tra];
  end

  assign trk_sel = (req_q == REQ_ADD) ? tg_q : prd_q.trunk;
  assign tra     = TAW'(32'(pipe_q) * NUM_TRUNKS + 32'(trk_sel));
  assign pra     = (state_q == S_WALK) ? wcnt_q : PAW'(port_i);
  assign tg_ok   = 32'(tg_q) < NUM_TRUNKS;
  assign wmatch  = wvld_q && prd_q.in_trunk && (prd_q.trunk == pe_q.trunk) &&
                   (prd_q.pipe == pipe_q);
  assign n_inc   = (wmatch && nmatch_q != 2'd2) ? nmatch_q + 2'd1 : nmatch_q;

  always_comb begin
    u_st    = ST_OK;
    u_id    = '0;
    u_tv    = 1'b0;
    u_tid   = '0;
    u_mw    = 1'b0;
    u_mc    = 1'b0;
    u_claim = 1'b0;
    u_rel   = 1'b0;
    u_pe    = pe_q;
    u_te    = trd_q;
    u_pwe   = 1'b0;
    u_twe   = 1'b0;
    unique case (req_q)
      REQ_ADD: begin
        if (tv_q) begin
          if (!tg_ok || pe_q.has_id) begin
            u_st = ST_BAD;
          end else if (pe_q.in_trunk && pe_q.trunk != tg_q) begin
            u_st = ST_BAD;
          end else if (pe_q.in_trunk && pe_q.cnt == CNT_MAX) begin
            u_st = ST_OVF;
          end else if (!pe_q.in_trunk && pe_q.cnt != '0) begin
            u_st = ST_BAD;
          end else if (trd_q.has_id && trd_q.cnt == CNT_MAX) begin
            u_st = ST_OVF;
          end else if (!trd_q.has_id && !fr.found) begin
            u_st = ST_FULL;
          end else begin
            if (trd_q.has_id) begin
              u_te.cnt = trd_q.cnt + 1'b1;
              u_id     = trd_q.id;
            end else begin
              u_te.has_id = 1'b1;
              u_te.id     = fr.id;
              u_te.cnt    = CNT_W'(1);
              u_id        = fr.id;
              u_claim     = 1'b1;
            end
            if (pe_q.in_trunk) begin
              u_pe.cnt = pe_q.cnt + 1'b1;
            end else begin
              u_pe.in_trunk = 1'b1;
              u_pe.trunk    = tg_q;
              u_pe.cnt      = CNT_W'(1);
              u_pe.pipe     = pipe_q;
              u_mw          = 1'b1;
            end
            u_pwe = 1'b1;
            u_twe = 1'b1;
          end
        end else begin
          if (pe_q.in_trunk) begin
            u_st = ST_BAD;
          end else if (pe_q.has_id) begin
            if (pe_q.cnt == CNT_MAX) begin
              u_st = ST_OVF;
            end else begin
              u_pe.cnt = pe_q.cnt + 1'b1;
              u_id     = pe_q.id;
              u_pwe    = 1'b1;
            end
          end else if (!fr.found) begin
            u_st = ST_FULL;
          end else begin
            u_claim     = 1'b1;
            u_pe.has_id = 1'b1;
            u_pe.id     = fr.id;
            u_pe.cnt    = CNT_W'(1);
            u_pe.pipe   = pipe_q;
            u_id        = fr.id;
            u_mw        = 1'b1;
            u_pwe       = 1'b1;
          end
        end
      end
      REQ_DEL: begin
        if (pe_q.in_trunk) begin
          if (pe_q.cnt == '0 || trd_q.cnt == '0) begin
            u_st = ST_BAD;
          end else begin
            u_id     = trd_q.has_id ? trd_q.id : '0;
            u_pe.cnt = pe_q.cnt - 1'b1;
            if (pe_q.cnt == CNT_W'(1)) begin
              u_mw          = 1'b1;
              u_mc          = 1'b1;
              u_pe.in_trunk = 1'b0;
              u_pe.trunk    = '0;
            end
            u_te.cnt = trd_q.cnt - 1'b1;
            if (trd_q.cnt == CNT_W'(1)) begin
              u_rel       = trd_q.has_id;
              u_te.has_id = 1'b0;
              u_te.id     = '0;
            end
            u_pwe = 1'b1;
            u_twe = 1'b1;
          end
        end else if (pe_q.cnt == '0) begin
          u_st = ST_BAD;
        end else begin
          u_id     = pe_q.has_id ? pe_q.id : '0;
          u_pe.cnt = pe_q.cnt - 1'b1;
          if (pe_q.cnt == CNT_W'(1)) begin
            u_mw        = 1'b1;
            u_mc        = 1'b1;
            u_rel       = pe_q.has_id;
            u_pe.has_id = 1'b0;
            u_pe.id     = '0;
          end
          u_pwe = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (pe_q.in_trunk) begin
          u_tv  = 1'b1;
          u_tid = pe_q.trunk;
          if (trd_q.has_id) u_id = trd_q.id;
          else u_st = ST_NOID;
        end else if (pe_q.has_id) begin
          u_id = pe_q.id;
        end else begin
          u_st = ST_NOID;
        end
      end
      REQ_LAST: u_st = ST_BAD;
      default: u_st = ST_BAD;
    endcase
    if (rbad_q) u_st = ST_BAD;
    if (u_st != ST_OK && u_st != ST_NOID) begin
      u_id    = '0;
      u_tv    = 1'b0;
      u_tid   = '0;
      u_mw    = 1'b0;
      u_mc    = 1'b0;
    end
    if (u_st != ST_OK) begin
      u_claim = 1'b0;
      u_rel   = 1'b0;
      u_pwe   = 1'b0;
      u_twe   = 1'b0;
    end
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    port_d   = port_q;
    pipe_d   = pipe_q;
    tv_d     = tv_q;
    tg_d     = tg_q;
    rbad_d   = rbad_q;
    pe_d     = pe_q;
    taddr_d  = taddr_q;
    wcnt_d   = wcnt_q;
    wvld_d   = wvld_q;
    nmatch_d = nmatch_q;
    clr_d    = clr_q;
    st_d     = st_q;
    id_d     = id_q;
    otv_d    = otv_q;
    otid_d   = otid_q;
    last_d   = last_q;
    mw_d     = mw_q;
    mc_d     = mc_q;
    pwe      = 1'b0;
    twe      = 1'b0;
    pwa      = PAW'(port_q);
    twa      = taddr_q;
    pwd      = u_pe;
    twd      = u_te;
    stall_o  = (state_q != S_IDLE);
    valid_o  = (state_q == S_OUT);
    unique case (state_q)
      S_CLR: begin
        pwe   = 32'(clr_q) < NUM_PORTS;
        twe   = 32'(clr_q) < TDEPTH;
        pwa   = PAW'(clr_q);
        twa   = TAW'(clr_q);
        pwd   = '0;
        twd   = '0;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == CLR_N - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (valid_i) begin
          req_d   = req_e'(req_type_i);
          port_d  = port_i;
          pipe_d  = pipe_i;
          tv_d    = trunk_valid_i;
          tg_d    = trunk_id_i;
          rbad_d  = (32'(port_i) >= NUM_PORTS) || (32'(pipe_i) >= PIPE_CNT);
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        pe_d    = prd_q;
        taddr_d = tra;
        if (req_q == REQ_LAST) begin
          if (rbad_q || !prd_q.in_trunk) begin
            st_d    = ST_BAD;
            id_d    = '0;
            otv_d   = 1'b0;
            otid_d  = '0;
            last_d  = 1'b0;
            mw_d    = 1'b0;
            mc_d    = 1'b0;
            state_d = S_OUT;
          end else begin
            wcnt_d   = '0;
            wvld_d   = 1'b0;
            nmatch_d = '0;
            state_d  = S_WALK;
          end
        end else begin
          state_d = S_TRD;
        end
      end
      S_TRD: begin
        pwe     = u_pwe;
        twe     = u_twe;
        st_d    = u_st;
        id_d    = u_id;
        otv_d   = u_tv;
        otid_d  = u_tid;
        last_d  = 1'b0;
        mw_d    = u_mw;
        mc_d    = u_mc;
        state_d = S_OUT;
      end
      S_WALK: begin
        nmatch_d = n_inc;
        wvld_d   = 1'b1;
        wcnt_d   = wcnt_q + 1'b1;
        if (32'(wcnt_q) == NUM_PORTS - 1) state_d = S_WEND;
      end
      S_WEND: begin
        st_d    = ST_OK;
        id_d    = '0;
        otv_d   = 1'b1;
        otid_d  = pe_q.trunk;
        last_d  = (n_inc <= 2'd1);
        mw_d    = 1'b0;
        mc_d    = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      for (int p = 0; p < PIPE_CNT; p++) used_q[p] <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == S_TRD) begin
        if (u_claim) used_q[pidx][fr.id[IW-1:0]] <= 1'b1;
        if (u_rel) used_q[pidx][u_id[IW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    port_q   <= port_d;
    pipe_q   <= pipe_d;
    tv_q     <= tv_d;
    tg_q     <= tg_d;
    rbad_q   <= rbad_d;
    pe_q     <= pe_d;
    taddr_q  <= taddr_d;
    wcnt_q   <= wcnt_d;
    wvld_q   <= wvld_d;
    nmatch_q <= nmatch_d;
    st_q     <= st_d;
    id_q     <= id_d;
    otv_q    <= otv_d;
    otid_q   <= otid_d;
    last_q   <= last_d;
    mw_q     <= mw_d;
    mc_q     <= mc_d;
  end

  assign status_o          = st_q;
  assign agg_id_o          = id_q;
  assign trunk_valid_out_o = otv_q;
  assign trunk_id_out_o    = otid_q;
  assign is_last_member_o  = last_q;
  assign map_write_o       = mw_q;
  assign map_clear_o       = mc_q;

  a_clr_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> stall_o && !valid_o)
    else $error("item taken during clearing pass");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> state_q == S_PRD)
    else $error("accepted item not started");

  a_clear_has_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && map_clear_o |-> map_write_o && status_o == ST_OK)
    else $error("map clear without write");

  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TRD && u_st != ST_OK |-> !u_pwe && !u_twe && !u_claim && !u_rel)
    else $error("failed item changes state");

endmodule
